// ----- sv/ipte_pkg.sv -----
// Shared types and constants of the inverted page table engine.
// Holds the entry and row layouts, request modes and stream payload layouts.
// Depends on nothing; every other file of the engine imports it.
package ipte_pkg;

    // Field widths fixed by the interface.
    localparam int OWNER_W    = 16;
    localparam int VADDR_W    = 32;
    localparam int PADDR_W    = 32;
    localparam int TGT_W      = 10;
    localparam int IDX_OUT_W  = 10;
    localparam int FREED_W    = 11;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // One table row holds this many frames; the scan checks one row a cycle.
    localparam int LANES      = 16;
    localparam int LANE_W     = 4;
    localparam int LANE_CNT_W = LANE_W + 1;

    // Request modes carried on the slave tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_TRANSLATE = 3'd0,
        MODE_SET_DIRTY = 3'd1,
        MODE_INSTALL   = 3'd2,
        MODE_FREE_ONE  = 3'd3,
        MODE_FREE_PROC = 3'd4,
        MODE_SEARCH    = 3'd5
    } mode_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

    // One frame entry of the table.
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [VADDR_W-1:0] vaddr;
        logic               writeable;
        logic               dirty;
    } entry_t;

    typedef entry_t [LANES-1:0] row_t;

    localparam entry_t RESET_ENTRY = '{owner: '0, vaddr: '0, writeable: 1'b1, dirty: 1'b0};
    localparam row_t   RESET_ROW   = {LANES{RESET_ENTRY}};

    // Summary of one row compared against a request.
    typedef struct packed {
        logic                  any_hit;
        logic [LANE_W-1:0]     first_lane;
        logic                  first_w;
        logic [LANE_CNT_W-1:0] hit_cnt;
    } lane_sum_t;

    // Slave tdata layout, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]         pad;
        logic               is_dirty;
        logic               can_write;
        logic [TGT_W-1:0]   target_frame;
        logic [VADDR_W-1:0] virt_addr;
        logic [OWNER_W-1:0] owner;
    } in_data_t;

    // Master tdata layout, last field in the lowest bits.
    typedef struct packed {
        logic [1:0]           pad;
        logic [FREED_W-1:0]   freed_count;
        logic                 write_ok;
        logic [IDX_OUT_W-1:0] frame_index;
        logic [PADDR_W-1:0]   phys_addr;
    } out_data_t;

endpackage

// ----- sv/ipte_table.sv -----
// Frame table memory of the inverted page table engine: one row of frames per word.
// One write port and one read port with registered read data. Depends on ipte_pkg.
module ipte_table
    import ipte_pkg::*;
#(
    parameter int ROWS  = 64,
    parameter int ROW_W = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [ROW_W-1:0] rd_addr,
    output row_t             rd_data,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_addr,
    input  row_t             wr_data
);

    row_t mem [ROWS];

    // Whole-row write, registered whole-row read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/ipte_lane_match.sv -----
// Row comparator of the inverted page table engine: checks all frames of one row
// against a request, finds the lowest hit, counts hits and builds the updated row.
// Depends on ipte_pkg.
module ipte_lane_match
    import ipte_pkg::*;
#(
    parameter int ROW_W     = 6,
    parameter int LIM_W     = 11,
    parameter int PAGE_BITS = 12
) (
    input  row_t               row_in,
    input  logic [ROW_W-1:0]   row_idx,
    input  logic [LIM_W-1:0]   lim,
    input  logic [OWNER_W-1:0] owner,
    input  logic [VADDR_W-1:0] vaddr,
    input  logic [MODE_W-1:0]  mode,
    output row_t               row_out,
    output lane_sum_t          sum
);

    localparam int FI_W = ROW_W + LANE_W;

    logic             exact;
    logic             whole;
    logic [LANES-1:0] hits;
    logic [LANES-1:0] first_oh;

    assign exact = (mode == MODE_FREE_ONE) || (mode == MODE_SEARCH);
    assign whole = (mode == MODE_FREE_PROC);

    // Per-frame compare: inside the scan bound, same owner, address match.
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        logic [FI_W-1:0]    idx;
        logic [VADDR_W-1:0] diff;
        logic               in_bound;
        logic               holds;
        logic               addr_ok;

        assign idx      = {row_idx, LANE_W'(j)};
        assign in_bound = LIM_W'(idx) < lim;
        assign diff     = vaddr - row_in[j].vaddr;
        assign holds    = (vaddr >= row_in[j].vaddr) && ((diff >> PAGE_BITS) == '0);
        assign addr_ok  = whole ? 1'b1 : (exact ? (vaddr == row_in[j].vaddr) : holds);
        assign hits[j]  = in_bound && (row_in[j].owner == owner) && addr_ok;
    end

    // Isolate the lowest hit.
    assign first_oh = hits & (~hits + LANES'(1));

    always_comb
    begin
        sum.any_hit    = |hits;
        sum.first_lane = '0;
        sum.first_w    = 1'b0;
        sum.hit_cnt    = LANE_CNT_W'($countones(hits));
        for (int j = 0; j < LANES; j++)
        begin
            if (first_oh[j])
            begin
                sum.first_lane = sum.first_lane | LANE_W'(j);
                sum.first_w    = sum.first_w | row_in[j].writeable;
            end
        end
    end

    // Updated row for set-dirty, free-one and free-process.
    always_comb
    begin
        row_out = row_in;
        for (int j = 0; j < LANES; j++)
        begin
            if ((mode == MODE_SET_DIRTY) && first_oh[j])
            begin
                row_out[j].dirty = 1'b1;
            end
            if (((mode == MODE_FREE_ONE) && first_oh[j]) || (whole && hits[j]))
            begin
                row_out[j].owner = '0;
                row_out[j].vaddr = '0;
            end
        end
    end

endmodule

// ----- sv/inverted_page_table_engine.sv -----
// Inverted page table engine: one entry per physical frame (owner, virtual page,
// writeable and dirty marks) kept in a table memory of 16 frames per row. After
// reset a clearing pass writes every row, during which no request is taken.
// Scanning requests read one row per cycle up to the row that holds the scan bound
// n = min(frames_in_use, FRAMES); translate, set-dirty, search and free-one stop at
// the row of the first hit. Install reads the target row, then writes it back with
// the new entry. One request is worked at a time; a new one may be taken while the
// previous result still waits on the master side.
module inverted_page_table_engine
    import ipte_pkg::*;
#(
    parameter int FRAMES    = 1024,
    parameter int PAGE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Requests: tdata = owner, virt_addr, target_frame, can_write, is_dirty, zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,
    // tuser = mode
    input  logic [MODE_W-1:0]     s_tuser,
    // Results: tdata = phys_addr, frame_index, write_ok, freed_count, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,
    // tuser = found
    output logic                  m_tuser,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROWS  = (FRAMES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FI_W  = ROW_W + LANE_W;
    localparam int CNT_A = ($clog2(FRAMES + 1) > FREED_W) ? $clog2(FRAMES + 1) : FREED_W;
    localparam int LIM_W = (CNT_A > FI_W) ? CNT_A : FI_W;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_INST_RD = 6'b001000,
        ST_INST_WR = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [OWNER_W-1:0]   owner_reg, owner_next;
    logic [VADDR_W-1:0]   va_reg, va_next;
    logic [TGT_W-1:0]     tgt_reg, tgt_next;
    logic                 cw_reg, cw_next;
    logic                 dt_reg, dt_next;
    logic [LIM_W-1:0]     lim_reg, lim_next;
    logic [ROW_W-1:0]     last_row_reg, last_row_next;
    logic [ROW_W:0]       issue_row_reg, issue_row_next;
    logic                 pv_reg, pv_next;
    logic [ROW_W-1:0]     pv_row_reg, pv_row_next;
    logic [LIM_W-1:0]     cnt_reg, cnt_next;
    logic                 res_found_reg, res_found_next;
    logic                 res_addr_reg, res_addr_next;
    logic [FI_W-1:0]      res_idx_reg, res_idx_next;
    logic                 res_wok_reg, res_wok_next;
    logic [PADDR_W-1:0]   frame_base_reg;
    logic [FREED_W-1:0]   frames_in_use_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    out_data_t            m_data_reg, m_data_next;
    logic                 m_found_reg, m_found_next;

    in_data_t             in_data;
    logic                 find_mode;
    logic                 scan_req;
    logic                 inst_req;
    logic [LIM_W-1:0]     lim_now;
    logic [LIM_W-1:0]     lim_m1;
    logic [LIM_W-1:0]     tgt_ext;
    logic [ROW_W-1:0]     tgt_row;
    logic [LANE_W-1:0]    tgt_lane;
    logic [LIM_W-1:0]     idx_ext;
    logic                 last_pv;
    logic                 load_out;

    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    row_t                 rd_data;
    logic                 wr_en;
    logic [ROW_W-1:0]     wr_addr;
    row_t                 wr_data;
    row_t                 row_mod;
    row_t                 inst_row;
    lane_sum_t            sum;

    // Table memory and row comparator.
    ipte_table #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ipte_lane_match #(
        .ROW_W     (ROW_W),
        .LIM_W     (LIM_W),
        .PAGE_BITS (PAGE_BITS)
    ) u_match (
        .row_in  (rd_data),
        .row_idx (pv_row_reg),
        .lim     (lim_reg),
        .owner   (owner_reg),
        .vaddr   (va_reg),
        .mode    (mode_reg),
        .row_out (row_mod),
        .sum     (sum)
    );

    // Request decode and scan bound.
    assign in_data   = in_data_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign find_mode = (mode_reg == MODE_TRANSLATE) || (mode_reg == MODE_SET_DIRTY) ||
                       (mode_reg == MODE_FREE_ONE) || (mode_reg == MODE_SEARCH);
    assign scan_req  = (s_tuser == MODE_TRANSLATE) || (s_tuser == MODE_SET_DIRTY) ||
                       (s_tuser == MODE_FREE_ONE) || (s_tuser == MODE_SEARCH) ||
                       (s_tuser == MODE_FREE_PROC);
    assign inst_req  = (s_tuser == MODE_INSTALL) &&
                       (LIM_W'(in_data.target_frame) < LIM_W'(FRAMES));
    assign lim_now   = (LIM_W'(frames_in_use_reg) > LIM_W'(FRAMES)) ?
                       LIM_W'(FRAMES) : LIM_W'(frames_in_use_reg);
    assign lim_m1    = lim_now - LIM_W'(1);
    assign tgt_ext   = LIM_W'(tgt_reg);
    assign tgt_row   = tgt_ext[LANE_W +: ROW_W];
    assign tgt_lane  = tgt_ext[LANE_W-1:0];
    assign idx_ext   = LIM_W'(res_idx_reg);
    assign last_pv   = (pv_row_reg == last_row_reg);

    // Row with the installed entry put in place.
    always_comb
    begin
        inst_row           = rd_data;
        inst_row[tgt_lane] = '{owner: owner_reg, vaddr: va_reg,
                               writeable: cw_reg, dirty: dt_reg};
    end

    // Sequencer: clearing pass, row scan with write-back, install, result hand-off.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        owner_next     = owner_reg;
        va_next        = va_reg;
        tgt_next       = tgt_reg;
        cw_next        = cw_reg;
        dt_next        = dt_reg;
        lim_next       = lim_reg;
        last_row_next  = last_row_reg;
        issue_row_next = issue_row_reg;
        pv_next        = pv_reg;
        pv_row_next    = pv_row_reg;
        cnt_next       = cnt_reg;
        res_found_next = res_found_reg;
        res_addr_next  = res_addr_reg;
        res_idx_next   = res_idx_reg;
        res_wok_next   = res_wok_reg;
        rd_en          = 1'b0;
        rd_addr        = issue_row_reg[ROW_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pv_row_reg;
        wr_data        = row_mod;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = issue_row_reg[ROW_W-1:0];
                wr_data = RESET_ROW;
                if (issue_row_reg[ROW_W-1:0] == ROW_W'(ROWS - 1))
                begin
                    issue_row_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    issue_row_next = issue_row_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next      = s_tuser;
                    owner_next     = in_data.owner;
                    va_next        = in_data.virt_addr;
                    tgt_next       = in_data.target_frame;
                    cw_next        = in_data.can_write;
                    dt_next        = in_data.is_dirty;
                    lim_next       = lim_now;
                    last_row_next  = lim_m1[LANE_W +: ROW_W];
                    issue_row_next = '0;
                    pv_next        = 1'b0;
                    cnt_next       = '0;
                    res_found_next = 1'b0;
                    res_addr_next  = 1'b0;
                    res_idx_next   = '0;
                    res_wok_next   = 1'b0;
                    if (scan_req && (lim_now != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (inst_req)
                    begin
                        state_next = ST_INST_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                // Read ahead one row while the previous row is compared.
                if (issue_row_reg <= {1'b0, last_row_reg})
                begin
                    rd_en          = 1'b1;
                    issue_row_next = issue_row_reg + 1'b1;
                end
                pv_next     = rd_en;
                pv_row_next = issue_row_reg[ROW_W-1:0];

                if (pv_reg)
                begin
                    if (find_mode)
                    begin
                        if (sum.any_hit)
                        begin
                            wr_en          = (mode_reg == MODE_SET_DIRTY) ||
                                             (mode_reg == MODE_FREE_ONE);
                            res_found_next = 1'b1;
                            res_addr_next  = 1'b1;
                            res_idx_next   = {pv_row_reg, sum.first_lane};
                            res_wok_next   = sum.first_w;
                            cnt_next       = (mode_reg == MODE_FREE_ONE) ?
                                             LIM_W'(1) : '0;
                            pv_next        = 1'b0;
                            state_next     = ST_FINISH;
                        end
                        else if (last_pv)
                        begin
                            pv_next    = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        wr_en    = sum.any_hit;
                        cnt_next = cnt_reg + LIM_W'(sum.hit_cnt);
                        if (last_pv)
                        begin
                            res_found_next = (cnt_next != '0);
                            pv_next        = 1'b0;
                            state_next     = ST_FINISH;
                        end
                    end
                end
            end

            ST_INST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = tgt_row;
                state_next = ST_INST_WR;
            end

            ST_INST_WR:
            begin
                wr_en          = 1'b1;
                wr_addr        = tgt_row;
                wr_data        = inst_row;
                res_found_next = 1'b1;
                res_addr_next  = 1'b1;
                res_idx_next   = tgt_ext[FI_W-1:0];
                res_wok_next   = cw_reg;
                state_next     = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        m_data_next  = m_data_reg;
        m_found_next = m_found_reg;
        if (load_out)
        begin
            m_tvalid_next            = 1'b1;
            m_found_next             = res_found_reg;
            m_data_next.pad          = '0;
            m_data_next.phys_addr    = res_addr_reg ?
                                       (frame_base_reg + (PADDR_W'(res_idx_reg) << PAGE_BITS)) :
                                       '0;
            m_data_next.frame_index  = idx_ext[IDX_OUT_W-1:0];
            m_data_next.write_ok     = res_wok_reg;
            m_data_next.freed_count  = cnt_reg[FREED_W-1:0];
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

    // State and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            issue_row_reg     <= '0;
            pv_reg            <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            frame_base_reg    <= '0;
            frames_in_use_reg <= FREED_W'(1024);
        end
        else
        begin
            state_reg     <= state_next;
            issue_row_reg <= issue_row_next;
            pv_reg        <= pv_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FRAME_BASE:    frame_base_reg    <= cfg_data;
                    REG_FRAMES_IN_USE: frames_in_use_reg <= cfg_data[FREED_W-1:0];
                    default:           frame_base_reg    <= frame_base_reg;
                endcase
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        owner_reg     <= owner_next;
        va_reg        <= va_next;
        tgt_reg       <= tgt_next;
        cw_reg        <= cw_next;
        dt_reg        <= dt_next;
        lim_reg       <= lim_next;
        last_row_reg  <= last_row_next;
        pv_row_reg    <= pv_row_next;
        cnt_reg       <= cnt_next;
        res_found_reg <= res_found_next;
        res_addr_reg  <= res_addr_next;
        res_idx_reg   <= res_idx_next;
        res_wok_reg   <= res_wok_next;
        m_data_reg    <= m_data_next;
        m_found_reg   <= m_found_next;
    end

    // The write-back row is never the row being read in the same cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("table read and write hit the same row");

    // Row data is only compared while a scan is running.
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == ST_SCAN))
        else $error("scan data pending outside a scan");

    // A scan hit lies below the scan bound.
    a_hit_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && res_addr_reg && (mode_reg != MODE_INSTALL))
        |-> (idx_ext < lim_reg))
        else $error("reported frame lies beyond the scan bound");

    // The freed count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (cnt_reg <= LIM_W'(FRAMES)))
        else $error("freed count exceeds table size");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the inverted page table engine.
// Drives page requests and configuration writes, predicts every reply from a
// shadow frame table and compares it field by field. Depends on ipte_pkg and the RTL.
module tb
    import ipte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAME_CNT  = 1024;
    localparam int          PAGE_SHIFT = 12;
    localparam logic [31:0] PAGE_SPAN  = 32'd1 << PAGE_SHIFT;

    // Mode codes the engine must ignore.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [OWNER_W-1:0] owner;
        logic [VADDR_W-1:0] va;
        logic [TGT_W-1:0]   tgt;
        logic               cw;
        logic               dt;
    } page_req_t;

    typedef struct packed {
        logic                 found;
        logic [PADDR_W-1:0]   phys;
        logic [IDX_OUT_W-1:0] idx;
        logic                 wok;
        logic [FREED_W-1:0]   freed;
    } page_reply_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the engine: registers and frame table.
    logic [31:0]        phys_base   = '0;
    logic [10:0]        scan_frames = 11'd1024;
    logic [15:0]        tab_owner [FRAME_CNT];
    logic [31:0]        tab_va    [FRAME_CNT];
    logic               tab_wr    [FRAME_CNT];
    logic               tab_dirty [FRAME_CNT];

    page_req_t          req_backlog [$];
    page_reply_t        reply_due   [$];
    page_req_t          bus_req      = '0;
    logic               bus_full     = 1'b0;
    int                 req_gap      = 0;
    int                 stall_left   = 0;
    logic               ready_nxt    = 1'b1;
    int                 req_idle_pct = 0;
    int                 rsp_idle_pct = 0;
    int                 cfg_writes   = 0;
    int                 bad_replies  = 0;

    // Recently installed pages, used to aim lookups at live entries.
    logic [15:0]        gen_own [$];
    logic [31:0]        gen_va  [$];

    inverted_page_table_engine #(
        .FRAMES    (FRAME_CNT),
        .PAGE_BITS (PAGE_SHIFT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Works out the reply of one request and applies its effect to the shadow table.
    function automatic page_reply_t expected_reply(page_req_t r);
        page_reply_t o;
        int          lim;
        int          hit;
        int          i;
        logic        exact;
        logic        match;
        o     = '0;
        hit   = -1;
        lim   = (scan_frames > FRAME_CNT) ? FRAME_CNT : int'(scan_frames);
        exact = (r.mode == MODE_FREE_ONE) || (r.mode == MODE_SEARCH);
        case (r.mode)
            MODE_TRANSLATE, MODE_SET_DIRTY, MODE_FREE_ONE, MODE_SEARCH:
            begin
                for (i = 0; i < lim && hit < 0; i++)
                begin
                    if (tab_owner[i] == r.owner)
                    begin
                        // Page ranges never wrap past the top of the address space.
                        if (exact)
                            match = (tab_va[i] == r.va);
                        else
                            match = (r.va >= tab_va[i]) && ((r.va - tab_va[i]) < PAGE_SPAN);
                        if (match)
                            hit = i;
                    end
                end
                if (hit >= 0)
                begin
                    o.found = 1'b1;
                    o.phys  = phys_base + (32'(hit) << PAGE_SHIFT);
                    o.idx   = IDX_OUT_W'(hit);
                    o.wok   = tab_wr[hit];
                    if (r.mode == MODE_SET_DIRTY)
                        tab_dirty[hit] = 1'b1;
                    if (r.mode == MODE_FREE_ONE)
                    begin
                        tab_owner[hit] = '0;
                        tab_va[hit]    = '0;
                        o.freed        = 11'd1;
                    end
                end
            end
            MODE_INSTALL:
            begin
                if (int'(r.tgt) < FRAME_CNT)
                begin
                    tab_owner[r.tgt] = r.owner;
                    tab_va[r.tgt]    = r.va;
                    tab_wr[r.tgt]    = r.cw;
                    tab_dirty[r.tgt] = r.dt;
                    o.found = 1'b1;
                    o.phys  = phys_base + (32'(r.tgt) << PAGE_SHIFT);
                    o.idx   = r.tgt;
                    o.wok   = r.cw;
                end
            end
            MODE_FREE_PROC:
            begin
                for (i = 0; i < lim; i++)
                begin
                    if (tab_owner[i] == r.owner)
                    begin
                        tab_owner[i] = '0;
                        tab_va[i]    = '0;
                        o.freed      = o.freed + 11'd1;
                    end
                end
                o.found = (o.freed != '0);
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // Request side: take the next request from the backlog or insert an idle burst.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                reply_due.push_back(expected_reply(bus_req));
                bus_full = 1'b0;
            end
            if (!bus_full)
            begin
                if (req_gap > 0)
                    req_gap--;
                else if (req_backlog.size() > 0)
                begin
                    if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct)
                        req_gap = $urandom_range(0, 10);
                    else
                    begin
                        bus_req  = req_backlog.pop_front();
                        bus_full = 1'b1;
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin
        in_data_t d;
        d = '{pad: '0, is_dirty: bus_req.dt, can_write: bus_req.cw,
              target_frame: bus_req.tgt, virt_addr: bus_req.va, owner: bus_req.owner};
        s_tvalid <= bus_full;
        s_tdata  <= d;
        s_tuser  <= bus_req.mode;
    end

    // Reply side: check each accepted reply and draw the next stall.
    always @(posedge clk)
    begin
        out_data_t   got;
        page_reply_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (reply_due.size() == 0)
                begin
                    bad_replies++;
                    if (bad_replies <= 10)
                        $display({"%0t: reply with none pending: found=%0d phys=%h",
                                  " idx=%0d wok=%0d freed=%0d"},
                                 $realtime, m_tuser, got.phys_addr, got.frame_index,
                                 got.write_ok, got.freed_count);
                end
                else
                begin
                    want = reply_due.pop_front();
                    if (m_tuser != want.found || got.phys_addr != want.phys ||
                        got.frame_index != want.idx || got.write_ok != want.wok ||
                        got.freed_count != want.freed)
                    begin
                        bad_replies++;
                        if (bad_replies <= 10)
                        begin
                            $display("%0t: reply mismatch", $realtime);
                            $display("  expected found=%0d phys=%h idx=%0d wok=%0d freed=%0d",
                                     want.found, want.phys, want.idx, want.wok, want.freed);
                            $display("  actual   found=%0d phys=%h idx=%0d wok=%0d freed=%0d",
                                     m_tuser, got.phys_addr, got.frame_index,
                                     got.write_ok, got.freed_count);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_nxt = 1'b0;
            end
            else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct)
            begin
                stall_left = $urandom_range(0, 10);
                ready_nxt  = 1'b0;
            end
            else
                ready_nxt = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ready_nxt;
    end

    // Register writes update the shadow registers when the engine takes them.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FRAME_BASE)
                phys_base = cfg_data;
            else
                scan_frames = cfg_data[10:0];
            cfg_writes++;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        int n0;
        n0 = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (cfg_writes == n0)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_req(input logic [MODE_W-1:0] md, input logic [15:0] own,
                             input logic [31:0] va, input logic [9:0] tgt,
                             input logic cw, input logic dt);
        page_req_t r;
        r = '{mode: md, owner: own, va: va, tgt: tgt, cw: cw, dt: dt};
        req_backlog.push_back(r);
    endtask

    // Holds the sender until every request has been answered.
    task automatic drain();
        while (req_backlog.size() != 0 || bus_full || reply_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int                ph;
        int                n;
        int                k;
        int                bound;
        int                fiu;
        int                pct;
        logic [31:0]       rnd;
        logic [31:0]       base;
        logic [31:0]       va;
        logic [15:0]       own;
        logic [9:0]        tgt;
        logic [MODE_W-1:0] md;
        logic [15:0]       owners [6];

        for (int i = 0; i < FRAME_CNT; i++)
        begin
            tab_owner[i] = '0;
            tab_va[i]    = '0;
            tab_wr[i]    = 1'b1;
            tab_dirty[i] = 1'b0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: free entries, top page, wrapping base, duplicates and frees.
        req_idle_pct = 15;
        rsp_idle_pct = 15;
        write_reg(REG_FRAME_BASE, 32'hFFFF_F000);
        write_reg(REG_FRAMES_IN_USE, 32'd1024);
        queue_req(MODE_TRANSLATE, 16'h0000, 32'h0000_0000, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_SEARCH,    16'h0000, 32'h0000_0000, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_INSTALL,   16'hFFFF, 32'hFFFF_F000, 10'd1023, 1'b1, 1'b1);
        queue_req(MODE_TRANSLATE, 16'hFFFF, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_SET_DIRTY, 16'hFFFF, 32'hFFFF_F800, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_INSTALL,   16'h1234, 32'h0040_2ABC, 10'd5, 1'b0, 1'b0);
        queue_req(MODE_TRANSLATE, 16'h1234, 32'h0040_3ABB, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_TRANSLATE, 16'h1234, 32'h0040_3ABC, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_TRANSLATE, 16'h1234, 32'h0040_2ABB, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_SEARCH,    16'h1234, 32'h0040_2ABC, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_INSTALL,   16'h1234, 32'h0040_2ABC, 10'd7, 1'b1, 1'b0);
        queue_req(MODE_TRANSLATE, 16'h1234, 32'h0040_2FFF, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_FREE_ONE,  16'h1234, 32'h0040_2ABC, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_TRANSLATE, 16'h1234, 32'h0040_2ABC, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_FREE_PROC, 16'h1234, 32'h0000_0000, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_FREE_PROC, 16'h0000, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 1'b1);
        queue_req(MODE_SPARE_A,   16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 1'b1);
        queue_req(MODE_SPARE_B,   16'h5A5A, 32'h1234_5678, 10'd9, 1'b1, 1'b0);
        queue_req(MODE_TRANSLATE, 16'hFFFF, 32'h0000_0000, 10'd0, 1'b0, 1'b0);
        drain();

        // An empty scan bound finds nothing, but install still stores.
        write_reg(REG_FRAMES_IN_USE, 32'd0);
        queue_req(MODE_TRANSLATE, 16'h0000, 32'h0000_0000, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_INSTALL,   16'h0055, 32'h0000_3000, 10'd3, 1'b0, 1'b1);
        drain();

        // A bound above the table size scans the whole table.
        write_reg(REG_FRAMES_IN_USE, 32'd1500);
        queue_req(MODE_TRANSLATE, 16'hFFFF, 32'hFFFF_FFFF, 10'd0, 1'b0, 1'b0);
        queue_req(MODE_TRANSLATE, 16'h0055, 32'h0000_3FFF, 10'd0, 1'b0, 1'b0);
        drain();

        // An install beyond the bound is stored but not seen until the bound grows.
        write_reg(REG_FRAMES_IN_USE, 32'd1);
        queue_req(MODE_INSTALL,   16'h0009, 32'h0000_9000, 10'd2, 1'b1, 1'b0);
        queue_req(MODE_TRANSLATE, 16'h0009, 32'h0000_9000, 10'd0, 1'b0, 1'b0);
        drain();
        write_reg(REG_FRAMES_IN_USE, 32'd3);
        queue_req(MODE_TRANSLATE, 16'h0009, 32'h0000_9ABC, 10'd0, 1'b0, 1'b0);
        drain();

        // Random part: installs followed by lookups aimed at live pages.
        owners[0] = 16'h0000;
        owners[1] = 16'hFFFF;
        for (int i = 2; i < 6; i++)
            owners[i] = 16'($urandom);
        for (ph = 0; ph < 6; ph++)
        begin
            rnd = $urandom;
            case (ph)
                0: begin base = 32'h0;                fiu = 1024; pct = 15; end
                1: begin base = {rnd[31:12], 12'h0};  fiu = 1;    pct = 40; end
                2: begin base = 32'hFFFF_F000;        fiu = 16;   pct = 25; end
                3: begin base = {rnd[31:12], 12'h0};  fiu = 17;   pct = 10; end
                4: begin base = rnd; fiu = $urandom_range(1, 1024); pct = 30; end
                default: begin base = 32'h8000_0000;  fiu = 1024; pct = 0;  end
            endcase
            write_reg(REG_FRAME_BASE, base);
            write_reg(REG_FRAMES_IN_USE, 32'(fiu));
            req_idle_pct = pct;
            rsp_idle_pct = pct;
            bound = (fiu > FRAME_CNT) ? FRAME_CNT : fiu;
            for (n = 0; n < 115; n++)
            begin
                rnd = $urandom;
                own = owners[$urandom_range(0, 5)];
                va  = $urandom;
                tgt = 10'($urandom_range(0, FRAME_CNT - 1));
                k   = $urandom_range(0, 99);
                if (k < 30)
                begin
                    md = MODE_INSTALL;
                    if ($urandom_range(0, 9) == 0)
                        own = rnd[31:16];
                    case ($urandom_range(0, 4))
                        0, 4: va = {va[31:12], 12'h0};
                        2: va = 32'hFFFF_F000 + $urandom_range(0, PAGE_SPAN - 1);
                        3: va = $urandom_range(0, 32'h3_FFFF);
                        default: ;
                    endcase
                    if (bound > 0 && $urandom_range(0, 3) != 0)
                        tgt = 10'($urandom_range(0, bound - 1));
                    gen_own.push_back(own);
                    gen_va.push_back(va);
                    if (gen_va.size() > 64)
                    begin
                        void'(gen_own.pop_front());
                        void'(gen_va.pop_front());
                    end
                end
                else if (k < 96)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: md = MODE_TRANSLATE;
                        4:          md = MODE_SET_DIRTY;
                        5, 6:       md = MODE_SEARCH;
                        7, 8:       md = MODE_FREE_ONE;
                        default:    md = MODE_FREE_PROC;
                    endcase
                    if (gen_va.size() > 0 && $urandom_range(0, 4) != 0)
                    begin
                        k   = $urandom_range(0, gen_va.size() - 1);
                        own = gen_own[k];
                        va  = gen_va[k];
                        if (md == MODE_SEARCH || md == MODE_FREE_ONE)
                        begin
                            if ($urandom_range(0, 7) == 0)
                                va = va ^ (32'd1 << $urandom_range(0, 31));
                        end
                        else
                        begin
                            // Offsets just inside and just outside the page.
                            case ($urandom_range(0, 7))
                                0: va = va - 32'd1;
                                1: va = va + PAGE_SPAN;
                                2: va = va + PAGE_SPAN - 32'd1;
                                default: va = va + $urandom_range(0, PAGE_SPAN - 1);
                            endcase
                        end
                    end
                end
                else
                    md = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
                queue_req(md, own, va, tgt, rnd[0], rnd[1]);
            end
            drain();
        end

        // Quiet tail: nothing more should arrive.
        repeat (80) @(negedge clk);
        if (bad_replies == 0 && reply_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop in case the engine hangs.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
